// File: rtl/assert_macros.svh
// Assertion helpers for the RTL files; included by pct_dec_fifo.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check an implication on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

`endif

// File: rtl/pct_dec_pkg.sv
// ----------------------------------------------------------------------------
// pct_dec_pkg
// Types, constants and helpers for the percent-escape decoder.
// ----------------------------------------------------------------------------
package pct_dec_pkg;

  localparam logic [7:0] PCT_CHAR = 8'h25;
  localparam int unsigned BURST_MAX = 3;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_HELD = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } result_t;

  // Up to three results caused by one input byte; entry 0 goes out first.
  typedef struct packed {
    logic [1:0]   cnt;
    result_t [2:0] r;
  } burst_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.nib = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.nib = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.nib = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.nib = 4'(c - 8'h57);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// File: rtl/pct_dec_core.sv
// ----------------------------------------------------------------------------
// pct_dec_core
// Escape tracking state and per-byte result generation.
// ----------------------------------------------------------------------------
module pct_dec_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output pct_dec_pkg::burst_t burst
);

  pct_dec_pkg::phase_t phase, phase_next;
  logic [7:0]          held;
  pct_dec_pkg::hex_t   hx_hi, hx_lo;

  assign hx_hi = pct_dec_pkg::hex_decode(held);
  assign hx_lo = pct_dec_pkg::hex_decode(in_byte);

  always_comb begin
    phase_next = pct_dec_pkg::PH_IDLE;
    unique case (phase)
      pct_dec_pkg::PH_PCT: begin
        phase_next = in_last ? pct_dec_pkg::PH_IDLE : pct_dec_pkg::PH_HELD;
      end
      pct_dec_pkg::PH_HELD: begin
        phase_next = pct_dec_pkg::PH_IDLE;
      end
      default: begin
        if (in_byte == pct_dec_pkg::PCT_CHAR && !in_last) begin
          phase_next = pct_dec_pkg::PH_PCT;
        end
      end
    endcase
  end

  always_comb begin
    burst.cnt  = 2'd0;
    burst.r[0] = '{data: in_byte, last: in_last};
    burst.r[1] = '{data: in_byte, last: in_last};
    burst.r[2] = '{data: in_byte, last: in_last};
    unique case (phase)
      pct_dec_pkg::PH_PCT: begin
        if (in_last) begin
          burst.cnt  = 2'd2;
          burst.r[0] = '{data: pct_dec_pkg::PCT_CHAR, last: 1'b0};
        end
      end
      pct_dec_pkg::PH_HELD: begin
        if (hx_hi.ok && hx_lo.ok) begin
          burst.cnt  = 2'd1;
          burst.r[0] = '{data: {hx_hi.nib, hx_lo.nib}, last: in_last};
        end else begin
          burst.cnt  = 2'd3;
          burst.r[0] = '{data: pct_dec_pkg::PCT_CHAR, last: 1'b0};
          burst.r[1] = '{data: held, last: 1'b0};
        end
      end
      default: begin
        if (!(in_byte == pct_dec_pkg::PCT_CHAR && !in_last)) begin
          burst.cnt = 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= pct_dec_pkg::PH_IDLE;
    end else if (take) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 8'h00;
    end else if (take && phase == pct_dec_pkg::PH_PCT) begin
      held <= in_byte;
    end
  end

endmodule

// File: rtl/pct_dec_fifo.sv
// ----------------------------------------------------------------------------
// pct_dec_fifo
// Result queue taking up to three entries per cycle and giving at most one.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pct_dec_fifo #(
  parameter int unsigned DEPTH_LOG2 = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  pct_dec_pkg::burst_t  burst,
  input  logic                 pop,
  output pct_dec_pkg::result_t head,
  output logic                 head_valid,
  output logic                 room
);

  localparam int unsigned DEPTH = 1 << DEPTH_LOG2;
  localparam int unsigned CW    = DEPTH_LOG2 + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ROOM_C  = CW'(DEPTH - pct_dec_pkg::BURST_MAX);

  pct_dec_pkg::result_t mem [DEPTH];
  logic [DEPTH_LOG2-1:0] wptr, rptr;
  logic [CW-1:0]         count, count_next;
  logic [1:0]            n_push;

  assign n_push     = push ? burst.cnt : 2'd0;
  assign head_valid = (count != '0);
  assign head       = mem[rptr];
  assign room       = (count <= ROOM_C);
  assign count_next = count + CW'(n_push) - CW'(pop);

  always_ff @(posedge clk) begin
    for (int k = 0; k < pct_dec_pkg::BURST_MAX; k++) begin
      if (push && (2'(k) < burst.cnt)) begin
        mem[wptr + DEPTH_LOG2'(k)] <= burst.r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + DEPTH_LOG2'(n_push);
      rptr  <= rptr + DEPTH_LOG2'(pop);
      count <= count_next;
    end
  end

  `ASSERT_CLK(a_count_bound, clk, rst, count <= DEPTH_C, "result queue overfilled")
  `ASSERT_IMPL(a_push_room, clk, rst, push && burst.cnt != 2'd0, room, "push without room")
  `ASSERT_IMPL(a_ptr_gap, clk, rst, count != DEPTH_C, DEPTH_LOG2'(count) == DEPTH_LOG2'(wptr - rptr), "pointers disagree with count")

endmodule

// File: rtl/percent_escape_decoder.sv
// ----------------------------------------------------------------------------
// percent_escape_decoder
// Decodes %XX escapes in a byte stream; malformed escapes pass through.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  tdata            tlast      tuser
//  s_axis   in         [7:0] in_byte    in_last    -
//  m_axis   out        [7:0] out_byte   out_last   -
//
//  One input transaction per cycle is sustained while the queue has room;
//  each byte yields 0 to 3 results, written into an 8-entry result queue
//  (DEPTH_LOG2 sets it) when the byte is taken and sent on m_axis in order,
//  at most one per cycle. s_axis_tready drops while the queue has fewer
//  than three free entries, so a long run of malformed escapes under m_axis
//  stalls throttles input. rst clears the escape phase and the queue.
//
module percent_escape_decoder #(
  parameter int unsigned DEPTH_LOG2 = 3
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast
);

  pct_dec_pkg::burst_t  burst;
  pct_dec_pkg::result_t head;
  logic                 take;
  logic                 room;

  // Accept whenever the queue can absorb a worst-case burst of three.
  assign s_axis_tready = room;
  assign take          = s_axis_tvalid && s_axis_tready;

  // Escape state machine: produces this byte's results combinationally.
  pct_dec_core u_core (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .in_byte (s_axis_tdata),
    .in_last (s_axis_tlast),
    .burst   (burst)
  );

  // Result queue decouples the burst writes from the one-per-cycle output.
  pct_dec_fifo #(
    .DEPTH_LOG2 (DEPTH_LOG2)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (take),
    .burst      (burst),
    .pop        (m_axis_tvalid && m_axis_tready),
    .head       (head),
    .head_valid (m_axis_tvalid),
    .room       (room)
  );

  assign m_axis_tdata = head.data;
  assign m_axis_tlast = head.last;

endmodule
